/* rtl/core/rss_pkg.sv */
package rss_pkg;

   // Command codes
   localparam logic [2:0] CMD_PUSH    = 3'd0;
   localparam logic [2:0] CMD_POP     = 3'd1;
   localparam logic [2:0] CMD_SWAP    = 3'd2;
   localparam logic [2:0] CMD_REVERSE = 3'd3;
   localparam logic [2:0] CMD_SEARCH  = 3'd4;
   localparam logic [2:0] CMD_CLEAR   = 3'd5;

   // Error codes
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
   localparam logic [1:0] ERR_SWAP      = 2'd3;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] value;
   } rss_req_type;

   typedef struct packed {
      logic signed [31:0] top_value;
      logic [4:0]         entry_total;
      logic               found;
      logic               is_empty;
      logic [1:0]         error_code;
   } rss_rsp_type;

   // Per-cycle orders to the cell row
   typedef struct packed {
      logic rot_up;   // cell i takes cell i+1
      logic rot_dn;   // cell i takes cell i-1
      logic load;     // head cell takes load data
      logic capture;  // latch key match
      logic ripple;   // pass found bit one cell on
   } rss_ctl_type;

   // Response control from sequencer
   typedef struct packed {
      logic       strobe;
      logic       found_sel;
      logic [1:0] err;
   } rss_rctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWAP_FWD,
      ST_SWAP_MID,
      ST_SWAP_BACK,
      ST_REV,
      ST_SEARCH
   } rss_state_type;

endpackage

/* rtl/core/reversible_search_stack.sv */
// Results: push, pop, clear, idle codes and reverse of at most one entry give their
//   result in the cycle after the transfer; reverse rotates the ring in ST_REV, swap
//   walks the bottom entry to the head and back, search ripples found down the cells.
// Throughput: one transfer per item; the next may be taken in the result cycle.
// Reset: synchronous, clears count, direction flag and sequencer; stored words are kept.
// The receiver cannot stall: each result shows on rsp_data for one cycle with rsp_strobe.
module reversible_search_stack
   import rss_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  rss_req_type req_data,
   output logic        rsp_strobe,
   output rss_rsp_type rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);

   // The ring of cells is rotated so that the top entry always sits in cell 0.
   // With rev clear, position k below the top is in cell k; with rev set it is
   // in cell DEPTH-k. Reverse rotates the bottom into cell 0 and flips rev.

   logic [DATA_WIDTH-1:0] word;
   logic [DATA_WIDTH-1:0] load_data;
   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic                  cell_found [DEPTH];
   logic [CW-1:0]         count;
   logic                  rev;
   rss_ctl_type           ctl;
   rss_rctl_type          rctl;
   logic signed [DATA_WIDTH-1:0] head_s;

   // push word and search key both use the low DATA_WIDTH bits
   assign word = DATA_WIDTH'($unsigned(req_data.value));

   rss_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmd       (req_data.cmd),
      .word      (word),
      .head_data (cell_data[0]),
      .busy      (busy),
      .ctl       (ctl),
      .load_data (load_data),
      .count     (count),
      .rev       (rev),
      .rctl      (rctl)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int NEXT = (i + 1) % DEPTH;
      localparam int PREV = (i + DEPTH - 1) % DEPTH;

      rss_ctl_type cell_ctl;
      logic        held;
      logic        chain_in;

      always_comb begin
         cell_ctl      = ctl;
         cell_ctl.load = ctl.load & (i == 0);
      end

      // cell holds a live entry when its distance from the top is below count
      if (i == 0) begin : g_head
         assign held     = (count != '0);
         assign chain_in = 1'b0;
      end else begin : g_body
         assign held     = rev ? (CW'(DEPTH - i) < count) : (CW'(i) < count);
         assign chain_in = cell_found[PREV];
      end

      rss_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .held      (held),
         .key       (word),
         .load_data (load_data),
         .from_prev (cell_data[PREV]),
         .from_next (cell_data[NEXT]),
         .found_in  (chain_in),
         .data_out  (cell_data[i]),
         .found_out (cell_found[i])
      );
   end

   // Result fields read the cells during the strobe cycle.
   assign head_s     = cell_data[0];
   assign rsp_strobe = rctl.strobe;

   always_comb begin
      rsp_data.top_value   = (count != '0) ? 32'(head_s) : '0;
      rsp_data.entry_total = 5'(count);
      rsp_data.found       = rctl.found_sel & cell_found[DEPTH-1];
      rsp_data.is_empty    = (count == '0);
      rsp_data.error_code  = rctl.err;
   end

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count <= CW'(DEPTH))
      else $error("entry count above depth");

   a_strobe_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result while sequencer busy");

   a_push_grows : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.cmd == CMD_PUSH && count < CW'(DEPTH))
      |=> (rsp_strobe && count == $past(count) + CW'(1)))
      else $error("push did not add an entry");

   a_swap_short : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.cmd == CMD_SWAP && count < CW'(2))
      |=> (rsp_strobe && rsp_data.error_code == ERR_SWAP))
      else $error("short swap not flagged");
`endif

endmodule

/* rtl/core/rss_cell.sv */
module rss_cell
   import rss_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  rss_ctl_type           ctl,
   input  logic                  held,
   input  logic [DATA_WIDTH-1:0] key,
   input  logic [DATA_WIDTH-1:0] load_data,
   input  logic [DATA_WIDTH-1:0] from_prev,
   input  logic [DATA_WIDTH-1:0] from_next,
   input  logic                  found_in,
   output logic [DATA_WIDTH-1:0] data_out,
   output logic                  found_out
);

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic                  found_ff, found_in_v;

   always_comb begin
      priority if (ctl.load) begin
         data_in = load_data;
      end else if (ctl.rot_up) begin
         data_in = from_next;
      end else if (ctl.rot_dn) begin
         data_in = from_prev;
      end else begin
         data_in = data_ff;
      end
   end

   always_comb begin
      priority if (ctl.capture) begin
         found_in_v = held & (data_ff == key);
      end else if (ctl.ripple) begin
         found_in_v = found_ff | found_in;
      end else begin
         found_in_v = found_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      found_ff <= found_in_v;
   end

   assign data_out  = data_ff;
   assign found_out = found_ff;

endmodule

/* rtl/core/rss_ctrl.sv */
module rss_ctrl
   import rss_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [2:0]                     cmd,
   input  logic [DATA_WIDTH-1:0]          word,
   input  logic [DATA_WIDTH-1:0]          head_data,
   output logic                           busy,
   output rss_ctl_type                    ctl,
   output logic [DATA_WIDTH-1:0]          load_data,
   output logic [$clog2(DEPTH+1)-1:0]     count,
   output logic                           rev,
   output rss_rctl_type                   rctl
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = $clog2(DEPTH);

   rss_state_type         state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  rev_ff, rev_in;
   logic [SW-1:0]         step_ff, step_in;
   logic [DATA_WIDTH-1:0] hold_ff, hold_in;
   rss_rctl_type          rctl_ff, rctl_in;
   logic                  last_step;

   assign last_step = (step_ff == SW'(1));

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      rev_in    = rev_ff;
      step_in   = step_ff;
      hold_in   = hold_ff;
      rctl_in   = '0;
      rctl_in.err = ERR_NONE;
      ctl       = '0;
      load_data = word;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (cmd)
                  CMD_PUSH: begin
                     rctl_in.strobe = 1'b1;
                     if (count_ff == CW'(DEPTH)) begin
                        rctl_in.err = ERR_OVERFLOW;
                     end else begin
                        ctl.rot_up = rev_ff;
                        ctl.rot_dn = !rev_ff;
                        ctl.load   = 1'b1;
                        count_in   = count_ff + CW'(1);
                     end
                  end
                  CMD_POP: begin
                     rctl_in.strobe = 1'b1;
                     if (count_ff == '0) begin
                        rctl_in.err = ERR_UNDERFLOW;
                     end else begin
                        ctl.rot_up = !rev_ff;
                        ctl.rot_dn = rev_ff;
                        count_in   = count_ff - CW'(1);
                     end
                  end
                  CMD_SWAP: begin
                     if (count_ff < CW'(2)) begin
                        rctl_in.strobe = 1'b1;
                        rctl_in.err    = ERR_SWAP;
                     end else begin
                        hold_in  = head_data;
                        step_in  = SW'(count_ff - CW'(1));
                        state_in = ST_SWAP_FWD;
                     end
                  end
                  CMD_REVERSE: begin
                     if (count_ff == '0) begin
                        rctl_in.strobe = 1'b1;
                     end else if (count_ff == CW'(1)) begin
                        rev_in         = !rev_ff;
                        rctl_in.strobe = 1'b1;
                     end else begin
                        step_in  = SW'(count_ff - CW'(1));
                        state_in = ST_REV;
                     end
                  end
                  CMD_SEARCH: begin
                     ctl.capture = 1'b1;
                     step_in     = SW'(DEPTH - 1);
                     state_in    = ST_SEARCH;
                  end
                  CMD_CLEAR: begin
                     count_in       = '0;
                     rev_in         = 1'b0;
                     rctl_in.strobe = 1'b1;
                  end
                  default: begin
                     rctl_in.strobe = 1'b1;
                  end
               endcase
            end
         end
         ST_SWAP_FWD: begin
            // walk the bottom entry round to the head cell
            ctl.rot_up = !rev_ff;
            ctl.rot_dn = rev_ff;
            step_in    = step_ff - SW'(1);
            if (last_step) begin
               state_in = ST_SWAP_MID;
            end
         end
         ST_SWAP_MID: begin
            ctl.load  = 1'b1;
            load_data = hold_ff;
            hold_in   = head_data;
            step_in   = SW'(count_ff - CW'(1));
            state_in  = ST_SWAP_BACK;
         end
         ST_SWAP_BACK: begin
            ctl.rot_up = rev_ff;
            ctl.rot_dn = !rev_ff;
            step_in    = step_ff - SW'(1);
            if (last_step) begin
               ctl.load       = 1'b1;
               load_data      = hold_ff;
               rctl_in.strobe = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_REV: begin
            ctl.rot_up = !rev_ff;
            ctl.rot_dn = rev_ff;
            step_in    = step_ff - SW'(1);
            if (last_step) begin
               rev_in         = !rev_ff;
               rctl_in.strobe = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            ctl.ripple = 1'b1;
            step_in    = step_ff - SW'(1);
            if (last_step) begin
               rctl_in.strobe    = 1'b1;
               rctl_in.found_sel = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rev_ff   <= 1'b0;
         step_ff  <= '0;
         rctl_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rev_ff   <= rev_in;
         step_ff  <= step_in;
         rctl_ff  <= rctl_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   assign busy  = (state_ff != ST_IDLE);
   assign count = count_ff;
   assign rev   = rev_ff;
   assign rctl  = rctl_ff;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import rss_pkg::*;

   localparam int STACK_DEPTH   = 16;
   localparam int QUIET_LIMIT   = 1000;   // cycles with no transfer and no result
   localparam int RANDOM_ITEMS  = 1900;
   localparam int CALM_TAIL     = 300;    // last items are sent back to back

   // Mirror of the stack plus the queue of results it predicts.
   class stack_scoreboard;
      logic [31:0] cells [STACK_DEPTH];
      bit   [4:0]  held;
      bit   [3:0]  top;
      bit          flipped;
      rss_rsp_type pending_results [$];
      int          failures;
      int          checked;
      int          hits;
      int          codes_seen [4];

      function new();
         foreach (cells[i]) cells[i] = '0;
         held    = '0;
         top     = '0;
         flipped = 1'b0;
      endfunction

      // ring slot of the entry k places below the top
      function bit [3:0] slot_at(int k);
         bit [3:0] off;
         off = k[3:0];
         return flipped ? top + off : top - off;
      endfunction

      function void note_command(rss_req_type req);
         rss_rsp_type want;
         bit   [3:0]  a;
         bit   [3:0]  b;
         logic [31:0] t;
         want = '0;
         case (req.cmd)
            CMD_PUSH: begin
               if (held >= STACK_DEPTH) begin
                  want.error_code = ERR_OVERFLOW;
               end else begin
                  top        = flipped ? top - 4'd1 : top + 4'd1;
                  cells[top] = req.value;
                  held++;
               end
            end
            CMD_POP: begin
               if (held == 0) begin
                  want.error_code = ERR_UNDERFLOW;
               end else begin
                  top = slot_at(1);
                  held--;
               end
            end
            CMD_SWAP: begin
               if (held < 2) begin
                  want.error_code = ERR_SWAP;
               end else begin
                  a        = slot_at(0);
                  b        = slot_at(held - 1);
                  t        = cells[a];
                  cells[a] = cells[b];
                  cells[b] = t;
               end
            end
            CMD_REVERSE: begin
               if (held > 0) begin
                  top     = slot_at(held - 1);
                  flipped = !flipped;
               end
            end
            CMD_SEARCH: begin
               for (int k = 0; k < held; k++) begin
                  if (cells[slot_at(k)] == req.value) want.found = 1'b1;
               end
            end
            CMD_CLEAR: begin
               held    = '0;
               top     = '0;
               flipped = 1'b0;
            end
            default: ;
         endcase
         if (held > 0) want.top_value = cells[top];
         want.entry_total = held;
         want.is_empty    = (held == 0);
         pending_results.push_back(want);
      endfunction

      function void check_result(rss_rsp_type got);
         rss_rsp_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %h, nothing outstanding", $time, got);
            failures++;
            return;
         end
         want = pending_results.pop_front();
         checked++;
         hits += got.found;
         codes_seen[got.error_code]++;
         if (got.top_value !== want.top_value) begin
            $display("%0t: top_value expected %0d got %0d",
                     $time, want.top_value, got.top_value);
            failures++;
         end
         if (got.entry_total !== want.entry_total) begin
            $display("%0t: entry_total expected %0d got %0d",
                     $time, want.entry_total, got.entry_total);
            failures++;
         end
         if (got.found !== want.found) begin
            $display("%0t: found expected %b got %b", $time, want.found, got.found);
            failures++;
         end
         if (got.is_empty !== want.is_empty) begin
            $display("%0t: is_empty expected %b got %b",
                     $time, want.is_empty, got.is_empty);
            failures++;
         end
         if (got.error_code !== want.error_code) begin
            $display("%0t: error_code expected %0d got %0d",
                     $time, want.error_code, got.error_code);
            failures++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   rss_req_type req_data;
   logic        rsp_strobe;
   rss_rsp_type rsp_data;

   stack_scoreboard sb = new();

   int          quiet_cycles;
   int          transfers;
   int          sent;
   bit          gaps_on;
   logic [31:0] recent_words [8];

   reversible_search_stack #(
      .DEPTH      (STACK_DEPTH),
      .DATA_WIDTH (32)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Monitor: everything is sampled at the rising edge in one process, so
   // the check of an older result always runs before the next transfer is
   // noted. The watchdog lives here too.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (rsp_strobe) begin
            sb.check_result(rsp_data);
            quiet_cycles = 0;
         end
         if (start && !busy) begin
            sb.note_command(req_data);
            transfers++;
            quiet_cycles = 0;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog, %0d quiet cycles, %0d results outstanding",
                     $time, quiet_cycles, sb.pending_results.size());
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic hold_off(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // Present one command at the falling edge and hold it until a rising edge
   // sees busy low; start stays high so back-to-back commands have no gap.
   task automatic send_command(logic [2:0] cmd, logic [31:0] word);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= '{cmd: cmd, value: word};
      do @(posedge clock); while (busy);
      sent++;
      if (cmd == CMD_PUSH) recent_words[3'($urandom_range(0, 7))] = word;
      if (gaps_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 8));
   endtask

   // Sender stops until the stack has answered everything.
   task automatic drain();
      hold_off(1);
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word(int from_recent);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < from_recent) return recent_words[3'($urandom_range(0, 7))];
      case ($urandom_range(0, 5))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // Mixed traffic once the stack holds something: search and pop dominate.
   function automatic logic [2:0] pick_op();
      int roll;
      roll = $urandom_range(0, 39);
      if (roll < 6)  return CMD_PUSH;
      if (roll < 16) return CMD_POP;
      if (roll < 22) return CMD_SWAP;
      if (roll < 28) return CMD_REVERSE;
      if (roll < 39) return CMD_SEARCH;
      return CMD_CLEAR;
   endfunction

   initial begin
      logic [2:0] op;
      int         fills;
      int         mixes;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      gaps_on  = 1'b0;
      foreach (recent_words[i]) recent_words[i] = $urandom;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty-stack errors, unused codes, one-, three- and four-entry cases
      send_command(CMD_POP,     32'h0);
      send_command(CMD_SWAP,    32'h0);
      send_command(CMD_REVERSE, 32'h0);
      send_command(CMD_SEARCH,  32'h0);
      send_command(3'd6,        32'hffff_ffff);
      send_command(3'd7,        32'h5555_aaaa);
      send_command(CMD_PUSH,    32'h7fff_ffff);
      send_command(CMD_SWAP,    32'h0);
      send_command(CMD_REVERSE, 32'h0);
      send_command(CMD_PUSH,    32'h8000_0000);
      send_command(CMD_PUSH,    32'hffff_ffff);
      send_command(CMD_SWAP,    32'h0);
      send_command(CMD_REVERSE, 32'h0);
      send_command(CMD_SEARCH,  32'h7fff_ffff);
      send_command(CMD_SEARCH,  32'h0000_0000);
      send_command(CMD_PUSH,    32'h0000_0000);
      send_command(CMD_SEARCH,  32'h0000_0000);
      send_command(CMD_POP,     32'h0);
      send_command(CMD_POP,     32'h0);
      send_command(CMD_CLEAR,   32'h0);
      send_command(CMD_POP,     32'h0);
      drain();

      // Random: mostly fill-then-mix episodes so the stack runs full, wraps
      // the ring in both directions and searches hit; some pure noise.
      while (sent < RANDOM_ITEMS) begin
         if (sent < RANDOM_ITEMS - CALM_TAIL) gaps_on = $urandom_range(0, 2) != 0;
         else gaps_on = 1'b0;
         if (sent > RANDOM_ITEMS / 2 && sent < RANDOM_ITEMS / 2 + 30) drain();
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               fills = $urandom_range(1, 19);   // past 16 forces overflow
               repeat (fills) send_command(CMD_PUSH, pick_word(20));
               mixes = $urandom_range(4, 24);
               repeat (mixes) begin
                  op = pick_op();
                  send_command(op, pick_word(op == CMD_SEARCH ? 60 : 20));
               end
               if ($urandom_range(0, 3) == 0) begin
                  repeat ($urandom_range(8, 20)) send_command(CMD_POP, $urandom);
               end
            end
            6, 7, 8: begin
               repeat (10) send_command(3'($urandom_range(0, 7)), pick_word(30));
            end
            default: send_command(CMD_CLEAR, $urandom);
         endcase
      end

      // Let the last results land, then check that no expected result is still outstanding.
      drain();
      repeat (2 * STACK_DEPTH + 4) @(posedge clock);
      if (sb.pending_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived",
                  $time, sb.pending_results.size());
         sb.failures++;
      end

      $display("Ran %0d commands, checked %0d results, %0d searches hit.",
               transfers, sb.checked, sb.hits);
      $display("Errors seen: %0d underflow, %0d overflow, %0d short swap; %0d mismatches.",
               sb.codes_seen[ERR_UNDERFLOW], sb.codes_seen[ERR_OVERFLOW],
               sb.codes_seen[ERR_SWAP], sb.failures);
      if (sb.failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
